FILE: rtl/core/tdq_pkg.sv
// package for the timer deadline queue: sizes, beat types, controller states
`default_nettype none
package tdq_pkg;
    localparam int DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int RES_W = $clog2(MAX_RESULTS + 1);
    localparam int RIDX_W = $clog2(MAX_RESULTS);
    localparam int TIME_W = 48;
    localparam int IVAL_W = 32;
    localparam int ID_W = 8;
    localparam int ENT_W = TIME_W + IVAL_W + ID_W;
    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [ID_W-1:0]   timer_id;
        logic [TIME_W-1:0] deadline;
        logic [IVAL_W-1:0] repeat_interval;
        logic [TIME_W-1:0] now;
    } t_in;

    typedef struct packed {
        logic [ID_W-1:0]   expired_id;
        logic              expired_valid;
        logic              earliest_changed;
        logic              queue_full;
        logic [TIME_W-1:0] next_deadline;
        logic              queue_empty;
        logic              last;
    } t_out;

    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [IVAL_W-1:0] interval;
        logic [ID_W-1:0]   id;
    } t_ent;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HEAD,
        S_POP_RD,
        S_POP,
        S_INS_START,
        S_INS_RD,
        S_INS_SCAN,
        S_INS_WR,
        S_INS_DONE,
        S_EMIT,
        S_EMIT_RD,
        S_FINAL_RD,
        S_FINAL
    } t_state;
endpackage
`default_nettype wire

FILE: rtl/core/tdq_ram.sv
// generic single-port ram with registered read
`default_nettype none
module tdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_addr,
    input  wire  [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/timer_deadline_queue.sv
// timer deadline queue: sorted circular store of timers with tick expiry and re-arm
//
//  beat  | dir | handshake        | payload
//  in    | in  | i_valid/o_stall  | tdq_pkg::t_in
//  out   | out | o_valid/i_stall  | tdq_pkg::t_out
//
// one item at a time; the store is a circular buffer in one ram
// add: head read, scan of up to count entries, shift of the tail
// tick: one pop per due timer, then a sorted insert per re-armed timer, then
// one beat per expired id with a ram read each (held while stalled)
// reset clears state, head, count and the output valid and last flags only; entry contents are unset until written
// the output beat holds while i_stall is high; no input is taken until the item is done
`default_nettype none
module timer_deadline_queue (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire tdq_pkg::t_in  i_data,
    output logic               o_valid,
    input  wire                i_stall,
    output tdq_pkg::t_out      o_data
);
    localparam int IW = tdq_pkg::IDX_W;
    localparam int CW = tdq_pkg::CNT_W;
    localparam int RW = tdq_pkg::RES_W;
    localparam int RIW = tdq_pkg::RIDX_W;
    localparam int TW = tdq_pkg::TIME_W;

    tdq_pkg::t_state r_state, n_state;
    logic [IW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    tdq_pkg::t_in  r_item, n_item;
    // expired list kept in a second ram, indexed by pop order
    logic [RW-1:0] r_npop, n_npop;
    logic [RW-1:0] r_k, n_k;
    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_j, n_j;
    tdq_pkg::t_ent r_new, n_new;
    tdq_pkg::t_ent r_carry, n_carry;
    logic          r_changed, n_changed;
    logic [TW-1:0] r_first, n_first;
    logic          r_ovalid, n_ovalid;
    tdq_pkg::t_out r_odata, n_odata;

    logic           m_we;
    logic [IW-1:0]  m_addr;
    tdq_pkg::t_ent  m_wdata, m_rdata;
    logic           x_we;
    logic [RIW-1:0] x_addr;
    tdq_pkg::t_ent  x_wdata, x_rdata;

    tdq_ram #(.WIDTH(tdq_pkg::ENT_W), .DEPTH(tdq_pkg::DEPTH)) u_store (
        .i_clk(i_clk), .i_we(m_we), .i_addr(m_addr), .i_wdata(m_wdata), .o_rdata(m_rdata)
    );
    tdq_ram #(.WIDTH(tdq_pkg::ENT_W), .DEPTH(tdq_pkg::MAX_RESULTS)) u_expired (
        .i_clk(i_clk), .i_we(x_we), .i_addr(x_addr), .i_wdata(x_wdata), .o_rdata(x_rdata)
    );

    function automatic logic [IW-1:0] wrap(input logic [IW-1:0] h, input logic [CW-1:0] o);
        logic [CW:0] s;
        s = {1'b0, o} + {{(CW + 1 - IW){1'b0}}, h};
        if (s >= (CW + 1)'(tdq_pkg::DEPTH)) begin
            s = s - (CW + 1)'(tdq_pkg::DEPTH);
        end
        return s[IW-1:0];
    endfunction

    logic [TW:0] w_sum;
    assign w_sum = {1'b0, r_item.now} + {{(TW + 1 - tdq_pkg::IVAL_W){1'b0}}, x_rdata.interval};

    always_comb begin
        n_state = r_state;
        case (r_state)
            tdq_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = tdq_pkg::S_HEAD;
                end
            end
            tdq_pkg::S_HEAD: begin
                if (r_item.cmd == tdq_pkg::CMD_ADD) begin
                    n_state = (r_count == CW'(tdq_pkg::DEPTH)) ? tdq_pkg::S_FINAL
                                                               : tdq_pkg::S_INS_RD;
                end else begin
                    n_state = tdq_pkg::S_POP;
                end
            end
            tdq_pkg::S_POP_RD: n_state = tdq_pkg::S_POP;
            tdq_pkg::S_POP: begin
                if (r_count != '0 && m_rdata.deadline <= r_item.now
                        && r_npop != RW'(tdq_pkg::MAX_RESULTS)) begin
                    n_state = tdq_pkg::S_POP_RD;
                end else begin
                    n_state = tdq_pkg::S_INS_START;
                end
            end
            tdq_pkg::S_INS_START: begin
                if (r_k == r_npop) begin
                    n_state = (r_npop == '0) ? tdq_pkg::S_FINAL_RD : tdq_pkg::S_EMIT_RD;
                end else begin
                    n_state = tdq_pkg::S_INS_DONE;
                end
            end
            tdq_pkg::S_INS_DONE: begin
                // x_rdata holds expired entry r_k
                if (x_rdata.interval != '0 && r_count != CW'(tdq_pkg::DEPTH)) begin
                    n_state = tdq_pkg::S_INS_RD;
                end else begin
                    n_state = tdq_pkg::S_INS_START;
                end
            end
            tdq_pkg::S_INS_RD: begin
                n_state = (r_pos == r_count) ? tdq_pkg::S_INS_WR : tdq_pkg::S_INS_SCAN;
            end
            tdq_pkg::S_INS_SCAN: begin
                if (m_rdata.deadline > r_new.deadline || r_pos + 1'b1 == r_count) begin
                    n_state = tdq_pkg::S_INS_WR;
                end else begin
                    n_state = tdq_pkg::S_INS_RD;
                end
            end
            tdq_pkg::S_INS_WR: begin
                if (r_j > r_count) begin
                    n_state = (r_item.cmd == tdq_pkg::CMD_ADD) ? tdq_pkg::S_FINAL_RD
                                                               : tdq_pkg::S_INS_START;
                end
            end
            tdq_pkg::S_EMIT_RD: n_state = tdq_pkg::S_EMIT;
            tdq_pkg::S_EMIT: begin
                if (!i_stall || !r_ovalid) begin
                    n_state = r_odata.last ? tdq_pkg::S_IDLE : tdq_pkg::S_EMIT_RD;
                end
            end
            tdq_pkg::S_FINAL_RD: n_state = tdq_pkg::S_FINAL;
            tdq_pkg::S_FINAL: begin
                if (r_ovalid && !i_stall) begin
                    n_state = tdq_pkg::S_IDLE;
                end
            end
            default: n_state = tdq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_head = r_head;
        n_count = r_count;
        n_item = r_item;
        n_npop = r_npop;
        n_k = r_k;
        n_pos = r_pos;
        n_j = r_j;
        n_new = r_new;
        n_carry = r_carry;
        n_changed = r_changed;
        n_first = r_first;
        n_ovalid = r_ovalid;
        n_odata = r_odata;
        m_we = 1'b0;
        m_addr = r_head;
        m_wdata = r_carry;
        x_we = 1'b0;
        x_addr = r_k[RIW-1:0];
        x_wdata = m_rdata;
        o_stall = (r_state != tdq_pkg::S_IDLE);
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            tdq_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_item = i_data;
                    n_npop = '0;
                    n_k = '0;
                    n_pos = '0;
                    n_new = '{deadline: i_data.deadline, interval: i_data.repeat_interval,
                              id: i_data.timer_id};
                end
            end
            tdq_pkg::S_HEAD: begin
                n_changed = (r_count == '0);
            end
            tdq_pkg::S_POP_RD: m_addr = r_head;
            tdq_pkg::S_POP: begin
                if (r_count != '0 && m_rdata.deadline <= r_item.now
                        && r_npop != RW'(tdq_pkg::MAX_RESULTS)) begin
                    x_we = 1'b1;
                    x_addr = r_npop[RIW-1:0];
                    n_npop = r_npop + 1'b1;
                    n_head = wrap(r_head, CW'(1));
                    n_count = r_count - 1'b1;
                    m_addr = wrap(r_head, CW'(1));
                end
            end
            tdq_pkg::S_INS_START: begin
                x_addr = r_k[RIW-1:0];
            end
            tdq_pkg::S_INS_DONE: begin
                n_k = r_k + 1'b1;
                n_pos = '0;
                n_new = '{deadline: w_sum[TW] ? {TW{1'b1}} : w_sum[TW-1:0],
                          interval: x_rdata.interval, id: x_rdata.id};
                m_addr = r_head;
            end
            tdq_pkg::S_INS_RD: begin
                m_addr = wrap(r_head, r_pos);
                n_j = r_pos;
                n_carry = r_new;
            end
            tdq_pkg::S_INS_SCAN: begin
                if (m_rdata.deadline > r_new.deadline) begin
                    n_j = r_pos;
                    n_pos = '0;
                end else begin
                    n_pos = r_pos + 1'b1;
                    n_j = r_pos + 1'b1;
                    m_addr = wrap(r_head, r_pos + 1'b1);
                end
                if (r_pos == '0 && r_item.cmd == tdq_pkg::CMD_ADD) begin
                    n_changed = (r_new.deadline < m_rdata.deadline);
                end
            end
            tdq_pkg::S_INS_WR: begin
                // write carry at slot j, read old slot j for the next write (alternating)
                if (r_j <= r_count) begin
                    m_addr = wrap(r_head, r_j);
                    if (r_pos[0] == 1'b0) begin
                        // read phase: fetch occupant
                        n_pos[0] = 1'b1;
                    end else begin
                        m_we = 1'b1;
                        m_wdata = r_carry;
                        n_carry = m_rdata;
                        n_j = r_j + 1'b1;
                        n_pos[0] = 1'b0;
                    end
                end
                if (r_j > r_count) begin
                    n_count = r_count + 1'b1;
                    n_pos = '0;
                end
            end
            tdq_pkg::S_EMIT_RD: begin
                x_addr = r_k[RIW-1:0];
            end
            tdq_pkg::S_FINAL_RD: m_addr = r_head;
            default: ;
        endcase
        // end of inserts, first deadline, emit beats and final beat
        if (r_state == tdq_pkg::S_INS_START && r_k == r_npop) begin
            n_k = '0;
            x_addr = '0;
            m_addr = r_head;
        end
        if (r_state == tdq_pkg::S_EMIT_RD) begin
            if (r_k == '0) begin
                n_first = m_rdata.deadline;
            end
        end
        if (r_state == tdq_pkg::S_EMIT && (!r_ovalid || !i_stall) && !n_ovalid
                && !r_odata.last) begin
            n_ovalid = 1'b1;
            n_odata = '0;
            n_odata.expired_id = x_rdata.id;
            n_odata.expired_valid = 1'b1;
            n_odata.queue_empty = (r_count == '0);
            n_odata.next_deadline = (r_count == '0) ? '0 : r_first;
            n_odata.last = (r_k + 1'b1 == r_npop);
            n_k = r_k + 1'b1;
        end
        if (r_state == tdq_pkg::S_FINAL && !r_ovalid && !r_odata.last) begin
            n_ovalid = 1'b1;
            n_odata = '0;
            n_odata.queue_full = (r_item.cmd == tdq_pkg::CMD_ADD)
                                 && (r_count == CW'(tdq_pkg::DEPTH)) && !r_changed
                                 && (r_k == '0) && (r_j == '0);
            n_odata.earliest_changed = (r_item.cmd == tdq_pkg::CMD_ADD) && r_changed
                                       && !n_odata.queue_full;
            n_odata.queue_empty = (r_count == '0);
            n_odata.next_deadline = (r_count == '0) ? '0 : m_rdata.deadline;
            n_odata.last = 1'b1;
        end
        if (r_state == tdq_pkg::S_IDLE) begin
            n_odata.last = 1'b0;
            n_j = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdq_pkg::S_IDLE;
            r_head <= '0;
            r_count <= '0;
            r_ovalid <= 1'b0;
            r_odata.last <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head <= n_head;
            r_count <= n_count;
            r_ovalid <= n_ovalid;
            r_odata <= n_odata;
        end
        r_item <= n_item;
        r_npop <= n_npop;
        r_k <= n_k;
        r_pos <= n_pos;
        r_j <= n_j;
        r_new <= n_new;
        r_carry <= n_carry;
        r_changed <= n_changed;
        r_first <= n_first;
    end

    assign o_valid = r_ovalid;
    assign o_data = r_odata;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(tdq_pkg::DEPTH)) else $error("count beyond depth");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != tdq_pkg::S_IDLE |-> o_stall) else $error("input taken while busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && i_stall |=> r_ovalid && $stable(r_odata)) else $error("beat lost");
    a_pop_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != tdq_pkg::S_IDLE |-> r_npop <= RW'(tdq_pkg::MAX_RESULTS))
        else $error("too many pops");
endmodule
`default_nettype wire
